// ===== rtl/rtp_pkg.sv =====
// shared types and constants for the rotate-translate-perspective core
// no dependencies
`timescale 1ns / 1ps

package rtp_pkg;

  localparam int unsigned MacW   = 33;
  localparam int unsigned DepthW = 16;
  localparam int unsigned QuotW  = 17;
  localparam int unsigned ScrW   = 16;
  localparam int unsigned CfgW   = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 184;

  localparam logic [QuotW-1:0]  QuotSat  = 17'h1FFFF;
  localparam logic [DepthW-1:0] DepthMax = 16'hFFFF;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROT_AB   = 3'd0,
    CFG_ROT_CD   = 3'd1,
    CFG_ROT_E    = 3'd2,
    CFG_TRANS_XY = 3'd3,
    CFG_TRANS_Z  = 3'd4,
    CFG_PROJ_H   = 3'd5,
    CFG_SCR_OFS  = 3'd6,
    CFG_UNUSED   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [MacW-1:0] x;
    logic signed [MacW-1:0] y;
    logic signed [MacW-1:0] z;
  } mac_t;

  // handshake between pipeline sections
  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

endpackage

// ===== rtl/rtp_rotate.sv =====
// rotation by the 3x3 matrix, translation and depth clamp, two stages
// depends on rtp_pkg
`timescale 1ns / 1ps

module rtp_rotate (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rtp_pkg::pipe_ctl_t     ctl_i,
  input  logic signed [15:0]     vx_i,
  input  logic signed [15:0]     vy_i,
  input  logic signed [15:0]     vz_i,
  input  logic [63:0]            rot_ab_i,
  input  logic [63:0]            rot_cd_i,
  input  logic [15:0]            rot_e_i,
  input  logic [63:0]            trans_xy_i,
  input  logic [31:0]            trans_z_i,
  output logic                   valid_o,
  output rtp_pkg::mac_t          mac_o,
  output logic [15:0]            depth_o
);
  import rtp_pkg::*;

  logic signed [15:0] coef [9];
  logic signed [31:0] prod_d [9];
  logic signed [31:0] prod_q [9];
  logic               v1_q, v2_q;
  logic signed [33:0] sum [3];
  logic signed [31:0] trans [3];
  mac_t               mac_d, mac_q;
  logic [15:0]        depth_d, depth_q;

  assign coef[0] = rot_ab_i[15:0];
  assign coef[1] = rot_ab_i[31:16];
  assign coef[2] = rot_ab_i[47:32];
  assign coef[3] = rot_ab_i[63:48];
  assign coef[4] = rot_cd_i[15:0];
  assign coef[5] = rot_cd_i[31:16];
  assign coef[6] = rot_cd_i[47:32];
  assign coef[7] = rot_cd_i[63:48];
  assign coef[8] = rot_e_i;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      prod_d[3*r]   = coef[3*r] * vx_i;
      prod_d[3*r+1] = coef[3*r+1] * vy_i;
      prod_d[3*r+2] = coef[3*r+2] * vz_i;
    end
  end

  assign trans[0] = trans_xy_i[31:0];
  assign trans[1] = trans_xy_i[63:32];
  assign trans[2] = trans_z_i;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = 34'(prod_q[3*r]) + 34'(prod_q[3*r+1]) + 34'(prod_q[3*r+2]);
    end
    // floor shift by 12 keeps bits 33:12
    mac_d.x = MacW'(trans[0]) + MacW'($signed(sum[0][33:12]));
    mac_d.y = MacW'(trans[1]) + MacW'($signed(sum[1][33:12]));
    mac_d.z = MacW'(trans[2]) + MacW'($signed(sum[2][33:12]));
    if (mac_d.z[MacW-1] || mac_d.z == '0) begin
      depth_d = '0;
    end else if (mac_d.z[MacW-2:DepthW] != '0) begin
      depth_d = DepthMax;
    end else begin
      depth_d = mac_d.z[DepthW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (ctl_i.en) begin
      v1_q <= ctl_i.valid;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      prod_q  <= prod_d;
      mac_q   <= mac_d;
      depth_q <= depth_d;
    end
  end

  assign valid_o = v2_q;
  assign mac_o   = mac_q;
  assign depth_o = depth_q;

endmodule

// ===== rtl/rtp_divide.sv =====
// pipelined restoring divider for (h << 12) / depth, one quotient bit per stage
// depends on rtp_pkg
`timescale 1ns / 1ps

module rtp_divide (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rtp_pkg::pipe_ctl_t  ctl_i,
  input  logic [15:0]         depth_i,
  input  logic [15:0]         proj_h_i,
  input  rtp_pkg::mac_t       mac_i,
  output logic                valid_o,
  output rtp_pkg::mac_t       mac_o,
  output logic [15:0]         depth_o,
  output logic [16:0]         quot_o,
  output logic                ovf_o
);
  import rtp_pkg::*;

  localparam int unsigned Steps = QuotW;

  logic              v_q     [Steps+1];
  logic [15:0]       rem_q   [Steps+1];
  logic [QuotW-1:0]  q_q     [Steps+1];
  logic [15:0]       div_q   [Steps+1];
  logic              sat_q   [Steps+1];
  mac_t              mac_q   [Steps+1];
  logic [27:0]       numer;

  assign numer = {proj_h_i, 12'b0};

  // quotient of 2^17 or more exactly when h >> 5 >= depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (ctl_i.en) begin
      v_q[0] <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      rem_q[0] <= {5'b0, numer[27:17]};
      q_q[0]   <= '0;
      div_q[0] <= depth_i;
      sat_q[0] <= (depth_i == '0) || ({5'b0, proj_h_i[15:5]} >= depth_i);
      mac_q[0] <= mac_i;
    end
  end

  for (genvar s = 0; s < Steps; s++) begin : g_step
    localparam int unsigned Bit = Steps - 1 - s;
    logic [16:0] trial;
    logic        ge;

    assign trial = {rem_q[s], numer[Bit]};
    assign ge    = trial >= {1'b0, div_q[s]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (ctl_i.en) begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q[s+1] <= ge ? 16'(trial - {1'b0, div_q[s]}) : trial[15:0];
        q_q[s+1]   <= {q_q[s][QuotW-2:0], ge};
        div_q[s+1] <= div_q[s];
        sat_q[s+1] <= sat_q[s];
        mac_q[s+1] <= mac_q[s];
      end
    end
  end

  assign valid_o = v_q[Steps];
  assign mac_o   = mac_q[Steps];
  assign depth_o = div_q[Steps];
  assign quot_o  = sat_q[Steps] ? QuotSat : q_q[Steps];
  assign ovf_o   = sat_q[Steps] || (q_q[Steps] == QuotSat);

endmodule

// ===== rtl/rtp_project.sv =====
// screen projection: mac times quotient, then offset add, two stages
// depends on rtp_pkg
`timescale 1ns / 1ps

module rtp_project (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rtp_pkg::pipe_ctl_t  ctl_i,
  input  rtp_pkg::mac_t       mac_i,
  input  logic [15:0]         depth_i,
  input  logic [16:0]         quot_i,
  input  logic                ovf_i,
  input  logic [63:0]         scr_ofs_i,
  output logic                valid_o,
  output logic [183:0]        data_o
);
  import rtp_pkg::*;

  logic signed [50:0] px_d, py_d, px_q, py_q;
  logic               v1_q, v2_q;
  mac_t               mac1_q;
  logic [15:0]        depth1_q;
  logic [16:0]        quot1_q;
  logic               ovf1_q;
  logic [15:0]        sx_d, sy_d;
  logic [183:0]       data_d, data_q;

  assign px_d = mac_i.x * $signed({1'b0, quot_i});
  assign py_d = mac_i.y * $signed({1'b0, quot_i});

  // only the low 16 bits of the sum survive
  assign sx_d = px_q[27:12] + scr_ofs_i[31:16];
  assign sy_d = py_q[27:12] + scr_ofs_i[63:48];

  assign data_d = {5'b0, depth1_q[15:2], sy_d, sx_d, ovf1_q, quot1_q, depth1_q,
                   mac1_q.z, mac1_q.y, mac1_q.x};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (ctl_i.en) begin
      v1_q <= ctl_i.valid;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      px_q     <= px_d;
      py_q     <= py_d;
      mac1_q   <= mac_i;
      depth1_q <= depth_i;
      quot1_q  <= quot_i;
      ovf1_q   <= ovf_i;
      data_q   <= data_d;
    end
  end

  assign valid_o = v2_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/rotate_translate_perspective_core.sv =====
// throughput one beat per cycle while the pipeline advances; beats pass through
// the rotate section, then the divider, then the projection section
// the whole pipeline advances when the output register is empty or taken
// reset clears all valid bits and the configuration registers to zero
// depends on rtp_pkg, rtp_rotate, rtp_divide, rtp_project
`timescale 1ns / 1ps

module rotate_translate_perspective_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // vertex_x[15:0], vertex_y[31:16], vertex_z[47:32]
  input  logic [rtp_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // mac_x[32:0], mac_y[65:33], mac_z[98:66], depth[114:99], quotient[131:115],
  // divide_overflow[132], screen_x[148:133], screen_y[164:149],
  // depth_quarter[178:165], zero fill above
  output logic [rtp_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [rtp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rtp_pkg::CfgW-1:0]      cfg_data_i
);
  import rtp_pkg::*;

  logic [63:0] rot_ab_q, rot_cd_q, trans_xy_q, scr_ofs_q;
  logic [15:0] rot_e_q, proj_h_q;
  logic [31:0] trans_z_q;

  logic        en;
  pipe_ctl_t   ctl_in, ctl_div, ctl_prj;
  logic        rot_valid, div_valid;
  mac_t        rot_mac, div_mac;
  logic [15:0] rot_depth, div_depth;
  logic [16:0] div_quot;
  logic        div_ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_ab_q   <= '0;
      rot_cd_q   <= '0;
      rot_e_q    <= '0;
      trans_xy_q <= '0;
      trans_z_q  <= '0;
      proj_h_q   <= '0;
      scr_ofs_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ROT_AB:   rot_ab_q   <= cfg_data_i;
        CFG_ROT_CD:   rot_cd_q   <= cfg_data_i;
        CFG_ROT_E:    rot_e_q    <= cfg_data_i[15:0];
        CFG_TRANS_XY: trans_xy_q <= cfg_data_i;
        CFG_TRANS_Z:  trans_z_q  <= cfg_data_i[31:0];
        CFG_PROJ_H:   proj_h_q   <= cfg_data_i[15:0];
        CFG_SCR_OFS:  scr_ofs_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  assign ctl_in  = '{en: en, valid: s_axis_tvalid};
  assign ctl_div = '{en: en, valid: rot_valid};
  assign ctl_prj = '{en: en, valid: div_valid};

  rtp_rotate u_rotate (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl_in),
    .vx_i       (s_axis_tdata[15:0]),
    .vy_i       (s_axis_tdata[31:16]),
    .vz_i       (s_axis_tdata[47:32]),
    .rot_ab_i   (rot_ab_q),
    .rot_cd_i   (rot_cd_q),
    .rot_e_i    (rot_e_q),
    .trans_xy_i (trans_xy_q),
    .trans_z_i  (trans_z_q),
    .valid_o    (rot_valid),
    .mac_o      (rot_mac),
    .depth_o    (rot_depth)
  );

  rtp_divide u_divide (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl_div),
    .depth_i  (rot_depth),
    .proj_h_i (proj_h_q),
    .mac_i    (rot_mac),
    .valid_o  (div_valid),
    .mac_o    (div_mac),
    .depth_o  (div_depth),
    .quot_o   (div_quot),
    .ovf_o    (div_ovf)
  );

  rtp_project u_project (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl_prj),
    .mac_i     (div_mac),
    .depth_i   (div_depth),
    .quot_i    (div_quot),
    .ovf_i     (div_ovf),
    .scr_ofs_i (scr_ofs_q),
    .valid_o   (m_axis_tvalid),
    .data_o    (m_axis_tdata)
  );

endmodule

// ===== tb/sv/rtp_checker.sv =====
// scoreboard for the rotate-translate-perspective core: mirrors the config port,
// predicts each output beat from the input beat and compares field by field; uses rtp_pkg
`timescale 1ns / 1ps

module rtp_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [rtp_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [rtp_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                         cfg_we_i,
  input  logic [rtp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rtp_pkg::CfgW-1:0]     cfg_data_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           checked_o,
  output int                           ovf_seen_o
);
  import rtp_pkg::*;

  localparam int NumFields = 10;
  localparam int FieldLsb[NumFields] = '{0, 33, 66, 99, 115, 132, 133, 149, 165, 179};
  localparam int FieldWid[NumFields] = '{33, 33, 33, 16, 17, 1, 16, 16, 14, 5};
  localparam string FieldName[NumFields] = '{"mac_x", "mac_y", "mac_z", "depth",
    "quotient", "divide_overflow", "screen_x", "screen_y", "depth_quarter", "zero_fill"};

  logic [63:0] rot_ab, rot_cd, trans_xy, scr_ofs;
  logic [15:0] rot_e, proj_h;
  logic [31:0] trans_z;

  logic [OutDataW-1:0] projected_q[$];

  function automatic longint s16(logic [15:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint s32(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic logic [OutDataW-1:0] project_vertex(logic [InDataW-1:0] d);
    longint vx, vy, vz, mx, my, mz, sx, sy;
    logic [63:0] dep, q;
    logic [OutDataW-1:0] r;
    vx = s16(d[15:0]);
    vy = s16(d[31:16]);
    vz = s16(d[47:32]);
    mx = s32(trans_xy[31:0]) + ((s16(rot_ab[15:0]) * vx + s16(rot_ab[31:16]) * vy
         + s16(rot_ab[47:32]) * vz) >>> 12);
    my = s32(trans_xy[63:32]) + ((s16(rot_ab[63:48]) * vx + s16(rot_cd[15:0]) * vy
         + s16(rot_cd[31:16]) * vz) >>> 12);
    mz = s32(trans_z) + ((s16(rot_cd[47:32]) * vx + s16(rot_cd[63:48]) * vy
         + s16(rot_e) * vz) >>> 12);
    if (mz <= 0) dep = 0;
    else if (mz > 64'(DepthMax)) dep = 64'(DepthMax);
    else dep = 64'(mz);
    if (dep == 0) begin
      q = 64'(QuotSat);
    end else begin
      q = ({48'd0, proj_h} << 12) / dep;
      if (q > 64'(QuotSat)) q = 64'(QuotSat);
    end
    sx = (s32(scr_ofs[31:0]) >>> 16) + ((mx * longint'(q)) >>> 12);
    sy = (s32(scr_ofs[63:32]) >>> 16) + ((my * longint'(q)) >>> 12);
    r = '0;
    r[32:0]    = mx[32:0];
    r[65:33]   = my[32:0];
    r[98:66]   = mz[32:0];
    r[114:99]  = dep[15:0];
    r[131:115] = q[16:0];
    r[132]     = (dep == 0) || (q == 64'(QuotSat));
    r[148:133] = sx[15:0];
    r[164:149] = sy[15:0];
    r[178:165] = dep[15:2];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [OutDataW-1:0] exp_beat;
    logic [63:0] ev, av;
    bit bad;
    if (!rst_ni) begin
      rot_ab <= '0; rot_cd <= '0; rot_e <= '0; trans_xy <= '0;
      trans_z <= '0; proj_h <= '0; scr_ofs <= '0;
      fail_count_o <= 0; checked_o <= 0; ovf_seen_o <= 0;
      projected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ROT_AB:   rot_ab   <= cfg_data_i;
          CFG_ROT_CD:   rot_cd   <= cfg_data_i;
          CFG_ROT_E:    rot_e    <= cfg_data_i[15:0];
          CFG_TRANS_XY: trans_xy <= cfg_data_i;
          CFG_TRANS_Z:  trans_z  <= cfg_data_i[31:0];
          CFG_PROJ_H:   proj_h   <= cfg_data_i[15:0];
          CFG_SCR_OFS:  scr_ofs  <= cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) projected_q.push_back(project_vertex(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        checked_o <= checked_o + 1;
        if (projected_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected output beat %h", m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_beat = projected_q.pop_front();
          bad = 0;
          if (exp_beat[132]) ovf_seen_o <= ovf_seen_o + 1;
          for (int f = 0; f < NumFields; f++) begin
            ev = 64'(exp_beat >> FieldLsb[f]) & ((64'd1 << FieldWid[f]) - 1);
            av = 64'(m_axis_tdata >> FieldLsb[f]) & ((64'd1 << FieldWid[f]) - 1);
            if (ev != av) begin
              bad = 1;
              if (fail_count_o < 10)
                $display("beat %0d %s: expected %h, got %h", checked_o, FieldName[f], ev, av);
            end
          end
          if (bad) fail_count_o <= fail_count_o + 1;
        end
      end
    end
  end

  assign pending_o = projected_q.size();
endmodule

// ===== tb/sv/testbench.sv =====
// top of the testbench: clock, reset, vertex stimulus, config phases and verdict
// depends on rtp_pkg, rotate_translate_perspective_core and rtp_checker
`timescale 1ns / 1ps

module testbench;
  import rtp_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 40;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic cfg_we_i = 0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;

  int fail_count, pending, checked, ovf_seen;
  int cycles = 0;
  bit idle_on = 1;
  bit long_hold = 0;

  always #4 clk_i = ~clk_i;

  rotate_translate_perspective_core u_top (.*);

  rtp_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked),
    .ovf_seen_o(ovf_seen)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout with %0d beats outstanding", pending);
      $display("** rotate_translate_perspective_core: FAILED **");
      $finish;
    end
  end

  // receiver side
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 0;
        repeat (400) @(posedge clk_i);
        long_hold = 0;
      end
      gap = idle_on ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
        m_axis_tready <= 0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [63:0] data);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic send_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    int gap;
    gap = idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {z, y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // even phases keep depth mostly inside the clamp window, odd ones are unconstrained
  task automatic random_setup(int p);
    logic [15:0] r33;
    if (p % 2 == 0) begin
      write_reg(CFG_ROT_AB, {$urandom, $urandom});
      write_reg(CFG_ROT_CD, {16'($urandom_range(0, 511) - 256), 16'($urandom_range(0, 511) - 256),
                             32'($urandom)});
      r33 = 16'($urandom_range(0, 8191) - 4096);
      write_reg(CFG_ROT_E, {48'd0, r33});
      write_reg(CFG_TRANS_Z, {32'd0, 32'($urandom_range(0, 140000) - 4000)});
    end else begin
      write_reg(CFG_ROT_AB, {pick16(), pick16(), pick16(), pick16()});
      write_reg(CFG_ROT_CD, {pick16(), pick16(), pick16(), pick16()});
      write_reg(CFG_ROT_E, {48'd0, pick16()});
      write_reg(CFG_TRANS_Z, {32'd0, $urandom});
    end
    write_reg(CFG_TRANS_XY, {$urandom, $urandom});
    write_reg(CFG_PROJ_H, {48'd0, ($urandom_range(0, 3) == 0) ? pick16() : 16'($urandom)});
    write_reg(CFG_SCR_OFS, {$urandom, $urandom});
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // identity rotation, no translation, modest projection distance
    write_reg(CFG_ROT_AB, {16'h0000, 16'h0000, 16'h0000, 16'h1000});
    write_reg(CFG_ROT_CD, {16'h0000, 16'h0000, 16'h0000, 16'h1000});
    write_reg(CFG_ROT_E, 64'h1000);
    write_reg(CFG_TRANS_XY, 64'd0);
    write_reg(CFG_TRANS_Z, 64'd0);
    write_reg(CFG_PROJ_H, 64'h0100);
    write_reg(CFG_SCR_OFS, {32'h0078_0000, 32'h00A0_0000});
    write_reg(CFG_UNUSED, {$urandom, $urandom});
    send_vertex(16'd0, 16'd0, 16'd0);          // zero depth
    send_vertex(16'd5, 16'd7, 16'd1);          // quotient saturates
    send_vertex(16'd0, 16'd0, 16'd8);          // quotient of exactly 2^17 saturates
    send_vertex(16'h7FFF, 16'h8000, 16'h7FFF);
    send_vertex(16'h8000, 16'h7FFF, 16'h8000); // negative depth
    send_vertex(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_vertex(16'd300, 16'hFF00, 16'd400);
    send_vertex(16'h7FFF, 16'h7FFF, 16'd16);   // screen wraps
    drain();

    // extremes everywhere
    write_reg(CFG_ROT_AB, {4{16'h8000}});
    write_reg(CFG_ROT_CD, {4{16'h7FFF}});
    write_reg(CFG_ROT_E, 64'h8000);
    write_reg(CFG_TRANS_XY, {32'h7FFF_FFFF, 32'h8000_0000});
    write_reg(CFG_TRANS_Z, 64'h7FFF_FFFF);
    write_reg(CFG_PROJ_H, 64'hFFFF);
    write_reg(CFG_SCR_OFS, {32'h8000_0000, 32'h7FFF_FFFF});
    send_vertex(16'h8000, 16'h8000, 16'h8000);
    send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_vertex(16'h8000, 16'h7FFF, 16'h0000);
    send_vertex(16'h0000, 16'h0000, 16'h0000);
    drain();
    write_reg(CFG_TRANS_Z, 64'h8000_0000);
    send_vertex(16'h7FFF, 16'h8000, 16'h7FFF);
    send_vertex(16'h0001, 16'hFFFF, 16'h0001);
    drain();

    for (int p = 0; p < 8; p++) begin
      random_setup(p);
      idle_on = (p % 3 != 2);
      if (p == 3) long_hold = 1;
      for (int i = 0; i < 85; i++) begin
        send_vertex(16'($urandom), 16'($urandom), 16'($urandom));
        // mid-phase the sender waits until every result is back
        if (p == 5 && i == 40) drain();
      end
      drain();
    end

    $display("checked %0d output beats across 11 configurations, %0d with divide overflow",
             checked, ovf_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("** rotate_translate_perspective_core: PASSED **");
    end else begin
      $display("%0d mismatching beats, %0d left outstanding", fail_count, pending);
      $display("** rotate_translate_perspective_core: FAILED **");
    end
    $finish;
  end
endmodule
